### src/xmt_pkg.sv
package xmt_pkg;

   // Element and DTD nesting limits; the counters are 8 bits wide.
   localparam int MAX_DEPTH    = 255;
   localparam int MAX_DTD_NEST = 255;
   localparam logic [7:0] DEPTH_LIMIT = 8'((MAX_DEPTH < 255) ? MAX_DEPTH : 255);
   localparam logic [7:0] NEST_LIMIT  = 8'((MAX_DTD_NEST < 255) ? MAX_DTD_NEST : 255);

   // Result queue sizing: one byte can release up to three results.
   localparam int MAX_RESULTS  = 3;
   localparam int RSP_Q_DEPTH  = 4;
   localparam int RSP_Q_PTR_W  = $clog2(RSP_Q_DEPTH);
   localparam int RSP_Q_CNT_W  = $clog2(RSP_Q_DEPTH + 1);

   // Characters the lexer looks for.
   localparam logic [7:0] CH_LT     = 8'h3C;
   localparam logic [7:0] CH_GT     = 8'h3E;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_QUEST  = 8'h3F;
   localparam logic [7:0] CH_BANG   = 8'h21;
   localparam logic [7:0] CH_DASH   = 8'h2D;
   localparam logic [7:0] CH_LBRACK = 8'h5B;
   localparam logic [7:0] CH_RBRACK = 8'h5D;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [2:0] CDATA_HDR_LEN = 3'd6;

   // Result kinds.
   localparam logic [1:0] KIND_CONTENT = 2'd0;
   localparam logic [1:0] KIND_MARKUP  = 2'd1;
   localparam logic [1:0] KIND_ERROR   = 2'd2;

   // Construct types.
   localparam logic [2:0] CT_END_TAG   = 3'd0;
   localparam logic [2:0] CT_START_TAG = 3'd1;
   localparam logic [2:0] CT_SELF_TAG  = 3'd2;
   localparam logic [2:0] CT_PI        = 3'd3;
   localparam logic [2:0] CT_COMMENT   = 3'd4;
   localparam logic [2:0] CT_CDATA     = 3'd5;
   localparam logic [2:0] CT_DTD       = 3'd6;

   // Error codes.
   localparam logic [2:0] ERR_NONE          = 3'd0;
   localparam logic [2:0] ERR_BAD_BANG      = 3'd1;
   localparam logic [2:0] ERR_CDATA_OUTSIDE = 3'd2;
   localparam logic [2:0] ERR_DEPTH         = 3'd3;
   localparam logic [2:0] ERR_END_IN_MARKUP = 3'd4;

   typedef enum logic [4:0] {
      ST_TEXT, ST_LT, ST_STAG, ST_ETAG, ST_PI, ST_PI_Q, ST_BANG, ST_BANG_DASH,
      ST_COM, ST_COM_D1, ST_COM_D2, ST_CDHDR, ST_CDATA, ST_DTD, ST_DLT,
      ST_DBANG, ST_DBANG_DASH, ST_DCOM, ST_DCOM_D1, ST_DCOM_D2, ST_DPI, ST_DPI_Q
   } lex_state_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_input;
   } req_item_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] out_byte;
      logic       construct_end;
      logic [2:0] construct_type;
      logic [2:0] error_code;
      logic [7:0] element_depth;
      logic       last_of_run;
   } rsp_item_type;

   // All results caused by one byte, in order from item[0].
   typedef struct packed {
      logic [1:0]              count;
      rsp_item_type [2:0]      item;
   } rsp_bundle_type;

   typedef struct packed {
      logic [RSP_Q_CNT_W-1:0] count;
      logic                   room;
   } rsp_q_status_type;

   // Expected byte of the "CDATA[" header at a given match position.
   function automatic logic [7:0] cdata_hdr_char(input logic [2:0] idx);
      logic [7:0] c;
      case (idx)
         3'd0:    c = 8'h43;
         3'd1:    c = 8'h44;
         3'd2:    c = 8'h41;
         3'd3:    c = 8'h54;
         3'd4:    c = 8'h41;
         3'd5:    c = 8'h5B;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

### src/xmt_channels_if.sv
// Request channel: one XML byte or the end-of-stream mark.
interface xmt_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       end_of_input;

   modport source (output valid, output in_byte, output end_of_input, input ready);
   modport sink   (input valid, input in_byte, input end_of_input, output ready);
endinterface

// Result channel: one tokenizer result.
interface xmt_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] out_byte;
   logic       construct_end;
   logic [2:0] construct_type;
   logic [2:0] error_code;
   logic [7:0] element_depth;
   logic       last_of_run;

   modport source (output valid, output kind, output out_byte, output construct_end,
                   output construct_type, output error_code, output element_depth,
                   output last_of_run, input ready);
   modport sink   (input valid, input kind, input out_byte, input construct_end,
                   input construct_type, input error_code, input element_depth,
                   input last_of_run, output ready);
endinterface

### src/xmt_lexer.sv
module xmt_lexer (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   input  xmt_pkg::req_item_type   item,
   output xmt_pkg::rsp_bundle_type bundle
);

   xmt_pkg::lex_state_type st_ff, st_in;
   logic [7:0] depth_ff, depth_in;
   logic [7:0] nest_ff, nest_in;
   logic [2:0] cdidx_ff, cdidx_in;
   logic [1:0] held_ff, held_in;
   logic       slash_ff, slash_in;
   logic       skip_ff, skip_in;

   logic [7:0] b;
   logic       eoi;
   logic       hit;
   logic [2:0] hit_code;
   logic       body_go;
   logic [7:0] body_nest;
   logic       body_close;
   logic       nest_full;
   logic [1:0] nres;
   xmt_pkg::rsp_item_type r0, r1, r2;

   assign b         = item.in_byte;
   assign eoi       = item.end_of_input;
   assign nest_full = (nest_ff >= xmt_pkg::NEST_LIMIT);

   // Error detection and the shared DTD-body decision.
   always_comb begin
      hit       = 1'b0;
      hit_code  = xmt_pkg::ERR_NONE;
      body_go   = 1'b0;
      body_nest = nest_ff;
      if (eoi) begin
         if (st_ff != xmt_pkg::ST_TEXT) begin
            hit      = 1'b1;
            hit_code = xmt_pkg::ERR_END_IN_MARKUP;
         end
      end else begin
         unique case (st_ff)
            xmt_pkg::ST_STAG: begin
               if (b == xmt_pkg::CH_GT && !slash_ff && depth_ff >= xmt_pkg::DEPTH_LIMIT) begin
                  hit      = 1'b1;
                  hit_code = xmt_pkg::ERR_DEPTH;
               end
            end
            xmt_pkg::ST_ETAG: begin
               if (b == xmt_pkg::CH_GT && depth_ff == 8'd0) begin
                  hit      = 1'b1;
                  hit_code = xmt_pkg::ERR_DEPTH;
               end
            end
            xmt_pkg::ST_BANG: begin
               if (b == xmt_pkg::CH_LBRACK) begin
                  if (depth_ff == 8'd0) begin
                     hit      = 1'b1;
                     hit_code = xmt_pkg::ERR_CDATA_OUTSIDE;
                  end
               end else if (b != xmt_pkg::CH_DASH) begin
                  body_go   = 1'b1;
                  body_nest = 8'd1;
               end
            end
            xmt_pkg::ST_BANG_DASH: begin
               if (b != xmt_pkg::CH_DASH) begin
                  hit      = 1'b1;
                  hit_code = xmt_pkg::ERR_BAD_BANG;
               end
            end
            xmt_pkg::ST_CDHDR: begin
               if (cdidx_ff >= xmt_pkg::CDATA_HDR_LEN || b != xmt_pkg::cdata_hdr_char(cdidx_ff)) begin
                  hit      = 1'b1;
                  hit_code = xmt_pkg::ERR_BAD_BANG;
               end
            end
            xmt_pkg::ST_DTD: begin
               body_go = 1'b1;
            end
            xmt_pkg::ST_DLT: begin
               if (b != xmt_pkg::CH_BANG && b != xmt_pkg::CH_QUEST && nest_full) begin
                  hit      = 1'b1;
                  hit_code = xmt_pkg::ERR_DEPTH;
               end
            end
            xmt_pkg::ST_DBANG, xmt_pkg::ST_DBANG_DASH: begin
               if (b != xmt_pkg::CH_DASH) begin
                  if (nest_full) begin
                     hit      = 1'b1;
                     hit_code = xmt_pkg::ERR_DEPTH;
                  end else begin
                     body_go   = 1'b1;
                     body_nest = nest_ff + 8'd1;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign body_close = body_go && (b == xmt_pkg::CH_GT) && (body_nest <= 8'd1);

   // Next state.
   always_comb begin
      st_in    = st_ff;
      depth_in = depth_ff;
      nest_in  = nest_ff;
      cdidx_in = cdidx_ff;
      held_in  = held_ff;
      slash_in = slash_ff;
      skip_in  = skip_ff;
      if (hit) begin
         st_in    = xmt_pkg::ST_TEXT;
         nest_in  = 8'd0;
         cdidx_in = 3'd0;
         held_in  = 2'd0;
         slash_in = 1'b0;
         skip_in  = 1'b0;
      end else if (!eoi) begin
         unique case (st_ff)
            xmt_pkg::ST_LT: begin
               if (b == xmt_pkg::CH_SLASH) begin
                  st_in = xmt_pkg::ST_ETAG;
               end else if (b == xmt_pkg::CH_QUEST) begin
                  st_in = xmt_pkg::ST_PI;
               end else if (b == xmt_pkg::CH_BANG) begin
                  st_in = xmt_pkg::ST_BANG;
               end else begin
                  st_in    = xmt_pkg::ST_STAG;
                  slash_in = 1'b0;
               end
            end
            xmt_pkg::ST_STAG: begin
               if (b != xmt_pkg::CH_GT) begin
                  slash_in = (b == xmt_pkg::CH_SLASH);
               end else begin
                  st_in = xmt_pkg::ST_TEXT;
                  if (slash_ff) begin
                     slash_in = 1'b0;
                  end else begin
                     depth_in = depth_ff + 8'd1;
                     skip_in  = 1'b1;
                  end
               end
            end
            xmt_pkg::ST_ETAG: begin
               if (b == xmt_pkg::CH_GT) begin
                  depth_in = depth_ff - 8'd1;
                  st_in    = xmt_pkg::ST_TEXT;
               end
            end
            xmt_pkg::ST_PI: begin
               if (b == xmt_pkg::CH_QUEST) st_in = xmt_pkg::ST_PI_Q;
            end
            xmt_pkg::ST_DPI: begin
               if (b == xmt_pkg::CH_QUEST) st_in = xmt_pkg::ST_DPI_Q;
            end
            xmt_pkg::ST_PI_Q: begin
               if (b == xmt_pkg::CH_GT) st_in = xmt_pkg::ST_TEXT;
               else if (b != xmt_pkg::CH_QUEST) st_in = xmt_pkg::ST_PI;
            end
            xmt_pkg::ST_DPI_Q: begin
               if (b == xmt_pkg::CH_GT) st_in = xmt_pkg::ST_DTD;
               else if (b != xmt_pkg::CH_QUEST) st_in = xmt_pkg::ST_DPI;
            end
            xmt_pkg::ST_BANG: begin
               if (b == xmt_pkg::CH_DASH) begin
                  st_in = xmt_pkg::ST_BANG_DASH;
               end else if (b == xmt_pkg::CH_LBRACK) begin
                  st_in    = xmt_pkg::ST_CDHDR;
                  cdidx_in = 3'd0;
               end
            end
            xmt_pkg::ST_BANG_DASH: begin
               st_in = xmt_pkg::ST_COM;
            end
            xmt_pkg::ST_COM: begin
               if (b == xmt_pkg::CH_DASH) st_in = xmt_pkg::ST_COM_D1;
            end
            xmt_pkg::ST_DCOM: begin
               if (b == xmt_pkg::CH_DASH) st_in = xmt_pkg::ST_DCOM_D1;
            end
            xmt_pkg::ST_COM_D1: begin
               st_in = (b == xmt_pkg::CH_DASH) ? xmt_pkg::ST_COM_D2 : xmt_pkg::ST_COM;
            end
            xmt_pkg::ST_DCOM_D1: begin
               st_in = (b == xmt_pkg::CH_DASH) ? xmt_pkg::ST_DCOM_D2 : xmt_pkg::ST_DCOM;
            end
            xmt_pkg::ST_COM_D2: begin
               if (b == xmt_pkg::CH_GT) st_in = xmt_pkg::ST_TEXT;
               else if (b != xmt_pkg::CH_DASH) st_in = xmt_pkg::ST_COM;
            end
            xmt_pkg::ST_DCOM_D2: begin
               if (b == xmt_pkg::CH_GT) st_in = xmt_pkg::ST_DTD;
               else if (b != xmt_pkg::CH_DASH) st_in = xmt_pkg::ST_DCOM;
            end
            xmt_pkg::ST_CDHDR: begin
               if (cdidx_ff + 3'd1 == xmt_pkg::CDATA_HDR_LEN) begin
                  cdidx_in = 3'd0;
                  held_in  = 2'd0;
                  st_in    = xmt_pkg::ST_CDATA;
               end else begin
                  cdidx_in = cdidx_ff + 3'd1;
               end
            end
            xmt_pkg::ST_CDATA: begin
               if (b == xmt_pkg::CH_RBRACK) begin
                  if (held_ff < 2'd2) held_in = held_ff + 2'd1;
               end else begin
                  held_in = 2'd0;
                  if (b == xmt_pkg::CH_GT && held_ff >= 2'd2) st_in = xmt_pkg::ST_TEXT;
               end
            end
            xmt_pkg::ST_DLT: begin
               if (b == xmt_pkg::CH_BANG) begin
                  st_in = xmt_pkg::ST_DBANG;
               end else if (b == xmt_pkg::CH_QUEST) begin
                  st_in = xmt_pkg::ST_DPI;
               end else begin
                  nest_in = nest_ff + 8'd1;
                  st_in   = xmt_pkg::ST_DTD;
               end
            end
            xmt_pkg::ST_DBANG: begin
               if (b == xmt_pkg::CH_DASH) st_in = xmt_pkg::ST_DBANG_DASH;
            end
            xmt_pkg::ST_DBANG_DASH: begin
               if (b == xmt_pkg::CH_DASH) st_in = xmt_pkg::ST_DCOM;
            end
            xmt_pkg::ST_DTD: begin
            end
            default: begin
               // Text outside markup.
               st_in = xmt_pkg::ST_TEXT;
               if (b == xmt_pkg::CH_LT) begin
                  skip_in = 1'b0;
                  st_in   = xmt_pkg::ST_LT;
               end else if (depth_ff != 8'd0 && !(skip_ff && b <= xmt_pkg::CH_SPACE)) begin
                  skip_in = 1'b0;
               end
            end
         endcase
         // Shared DTD body: '<' opens a nested item, '>' closes one level.
         if (body_go) begin
            st_in   = xmt_pkg::ST_DTD;
            nest_in = body_nest;
            if (b == xmt_pkg::CH_LT) begin
               st_in = xmt_pkg::ST_DLT;
            end else if (b == xmt_pkg::CH_GT) begin
               if (body_close) begin
                  nest_in = 8'd0;
                  st_in   = xmt_pkg::ST_TEXT;
               end else begin
                  nest_in = body_nest - 8'd1;
               end
            end
         end
      end
   end

   // Results caused by this byte.
   always_comb begin
      nres = 2'd1;
      r0   = '0;
      r0.kind     = xmt_pkg::KIND_MARKUP;
      r0.out_byte = b;
      r1   = '0;
      r1.kind     = xmt_pkg::KIND_CONTENT;
      r1.out_byte = xmt_pkg::CH_RBRACK;
      r2   = r1;
      if (hit) begin
         r0.kind       = xmt_pkg::KIND_ERROR;
         r0.out_byte   = eoi ? 8'd0 : b;
         r0.error_code = hit_code;
      end else if (eoi) begin
         nres = 2'd0;
      end else if (body_close) begin
         r0.construct_end  = 1'b1;
         r0.construct_type = xmt_pkg::CT_DTD;
      end else begin
         unique case (st_ff)
            xmt_pkg::ST_STAG: begin
               if (b == xmt_pkg::CH_GT) begin
                  r0.construct_end  = 1'b1;
                  r0.construct_type = slash_ff ? xmt_pkg::CT_SELF_TAG : xmt_pkg::CT_START_TAG;
               end
            end
            xmt_pkg::ST_ETAG: begin
               if (b == xmt_pkg::CH_GT) begin
                  r0.construct_end  = 1'b1;
                  r0.construct_type = xmt_pkg::CT_END_TAG;
               end
            end
            xmt_pkg::ST_PI_Q: begin
               if (b == xmt_pkg::CH_GT) begin
                  r0.construct_end  = 1'b1;
                  r0.construct_type = xmt_pkg::CT_PI;
               end
            end
            xmt_pkg::ST_COM_D2: begin
               if (b == xmt_pkg::CH_GT) begin
                  r0.construct_end  = 1'b1;
                  r0.construct_type = xmt_pkg::CT_COMMENT;
               end
            end
            xmt_pkg::ST_CDATA: begin
               if (b == xmt_pkg::CH_RBRACK) begin
                  // Up to two brackets are held; a third releases one.
                  if (held_ff < 2'd2) begin
                     nres = 2'd0;
                  end else begin
                     r0.kind = xmt_pkg::KIND_CONTENT;
                  end
               end else if (b == xmt_pkg::CH_GT && held_ff >= 2'd2) begin
                  nres              = 2'd3;
                  r0.out_byte       = xmt_pkg::CH_RBRACK;
                  r1.kind           = xmt_pkg::KIND_MARKUP;
                  r2.kind           = xmt_pkg::KIND_MARKUP;
                  r2.out_byte       = b;
                  r2.construct_end  = 1'b1;
                  r2.construct_type = xmt_pkg::CT_CDATA;
               end else begin
                  // Held brackets go out as content ahead of the byte.
                  r0.kind = xmt_pkg::KIND_CONTENT;
                  case (held_ff)
                     2'd0: begin
                        nres = 2'd1;
                     end
                     2'd1: begin
                        nres        = 2'd2;
                        r0.out_byte = xmt_pkg::CH_RBRACK;
                        r1.out_byte = b;
                     end
                     default: begin
                        nres        = 2'd3;
                        r0.out_byte = xmt_pkg::CH_RBRACK;
                        r2.out_byte = b;
                     end
                  endcase
               end
            end
            xmt_pkg::ST_LT, xmt_pkg::ST_PI, xmt_pkg::ST_DPI, xmt_pkg::ST_DPI_Q,
            xmt_pkg::ST_BANG, xmt_pkg::ST_BANG_DASH, xmt_pkg::ST_COM, xmt_pkg::ST_DCOM,
            xmt_pkg::ST_COM_D1, xmt_pkg::ST_DCOM_D1, xmt_pkg::ST_DCOM_D2,
            xmt_pkg::ST_CDHDR, xmt_pkg::ST_DTD, xmt_pkg::ST_DLT, xmt_pkg::ST_DBANG,
            xmt_pkg::ST_DBANG_DASH: begin
            end
            default: begin
               // Text: content only inside an element, minus leading blanks.
               if (b != xmt_pkg::CH_LT) begin
                  r0.kind = xmt_pkg::KIND_CONTENT;
                  if (depth_ff == 8'd0 || (skip_ff && b <= xmt_pkg::CH_SPACE)) begin
                     nres = 2'd0;
                  end
               end
            end
         endcase
      end
      r0.element_depth = depth_in;
      r1.element_depth = depth_in;
      r2.element_depth = depth_in;
      r0.last_of_run   = (nres == 2'd1);
      r1.last_of_run   = (nres == 2'd2);
      r2.last_of_run   = (nres == 2'd3);
      bundle.count   = nres;
      bundle.item[0] = r0;
      bundle.item[1] = r1;
      bundle.item[2] = r2;
   end

   // Lexer state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff    <= xmt_pkg::ST_TEXT;
         depth_ff <= 8'd0;
         nest_ff  <= 8'd0;
         cdidx_ff <= 3'd0;
         held_ff  <= 2'd0;
         slash_ff <= 1'b0;
         skip_ff  <= 1'b0;
      end else if (step) begin
         st_ff    <= st_in;
         depth_ff <= depth_in;
         nest_ff  <= nest_in;
         cdidx_ff <= cdidx_in;
         held_ff  <= held_in;
         slash_ff <= slash_in;
         skip_ff  <= skip_in;
      end
   end

endmodule

### src/xmt_rsp_queue.sv
module xmt_rsp_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  xmt_pkg::rsp_bundle_type   bundle,
   output xmt_pkg::rsp_q_status_type status,
   xmt_rsp_if.source                 rsp
);

   xmt_pkg::rsp_item_type mem [xmt_pkg::RSP_Q_DEPTH];
   logic [xmt_pkg::RSP_Q_PTR_W-1:0] wr_ff, wr_in;
   logic [xmt_pkg::RSP_Q_PTR_W-1:0] rd_ff, rd_in;
   logic [xmt_pkg::RSP_Q_CNT_W-1:0] cnt_ff, cnt_in;
   logic [xmt_pkg::RSP_Q_CNT_W-1:0] n_push;
   logic pop;

   assign pop    = rsp.valid && rsp.ready;
   assign n_push = push ? xmt_pkg::RSP_Q_CNT_W'(bundle.count) : '0;

   // Pointer and fill count update.
   always_comb begin
      wr_in  = wr_ff + xmt_pkg::RSP_Q_PTR_W'(n_push);
      rd_in  = rd_ff + xmt_pkg::RSP_Q_PTR_W'(pop);
      cnt_in = cnt_ff + n_push - xmt_pkg::RSP_Q_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // Up to three results are written in the same cycle at consecutive slots.
   always_ff @(posedge clock) begin
      if (push) begin
         if (bundle.count >= 2'd1) mem[wr_ff] <= bundle.item[0];
         if (bundle.count >= 2'd2) mem[wr_ff + xmt_pkg::RSP_Q_PTR_W'(1)] <= bundle.item[1];
         if (bundle.count >= 2'd3) mem[wr_ff + xmt_pkg::RSP_Q_PTR_W'(2)] <= bundle.item[2];
      end
   end

   // Room for a whole worst-case bundle.
   assign status.count = cnt_ff;
   assign status.room  =
      (cnt_ff <= xmt_pkg::RSP_Q_CNT_W'(xmt_pkg::RSP_Q_DEPTH - xmt_pkg::MAX_RESULTS));

   assign rsp.valid          = (cnt_ff != '0);
   assign rsp.kind           = mem[rd_ff].kind;
   assign rsp.out_byte       = mem[rd_ff].out_byte;
   assign rsp.construct_end  = mem[rd_ff].construct_end;
   assign rsp.construct_type = mem[rd_ff].construct_type;
   assign rsp.error_code     = mem[rd_ff].error_code;
   assign rsp.element_depth  = mem[rd_ff].element_depth;
   assign rsp.last_of_run    = mem[rd_ff].last_of_run;

endmodule

### src/xml_markup_tokenizer_core.sv
// XML markup tokenizer: takes one byte of an XML stream per request and returns
// tokenizer results. Markup bytes are passed through (kind 1) with the closing
// byte of each tag, PI, comment, CDATA section or DTD flagged; content inside
// elements comes out as kind 0; faults come out as kind 2 with an error code.
// One request is taken every clock while the result side keeps up. Most bytes
// give zero or one result; a byte inside CDATA that releases held ']' brackets
// gives up to three, which leave a four-entry result queue one per clock while
// the result side is ready. A request is held in the input register until the
// queue has three free slots; with at most one result per request and a ready
// result side the fill stays at one, so requests still flow one per clock, and
// only bursts of multi-result requests or a stalled result side slow the input.
// Accepted requests go from the input register through the lexer into the result
// queue; the last result of each request that gives results carries last_of_run.
module xml_markup_tokenizer_core (
   input  logic      clock,
   input  logic      reset,
   xmt_req_if.sink   req_ch,
   xmt_rsp_if.source rsp_ch
);

   xmt_pkg::req_item_type     item_ff, item_in;
   logic                      item_vld_ff, item_vld_in;
   logic                      req_fire;
   logic                      proc;
   xmt_pkg::rsp_bundle_type   bundle;
   xmt_pkg::rsp_q_status_type q_status;

   // Input register: refilled when empty or when its request moves to the lexer.
   assign proc         = item_vld_ff && q_status.room;
   assign req_ch.ready = !item_vld_ff || proc;
   assign req_fire     = req_ch.valid && req_ch.ready;

   always_comb begin
      item_in     = item_ff;
      item_vld_in = item_vld_ff;
      if (req_fire) begin
         item_in.in_byte      = req_ch.in_byte;
         item_in.end_of_input = req_ch.end_of_input;
         item_vld_in          = 1'b1;
      end else if (proc) begin
         item_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_vld_ff <= 1'b0;
      end else begin
         item_vld_ff <= item_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   xmt_lexer u_lexer (
      .clock  (clock),
      .reset  (reset),
      .step   (proc),
      .item   (item_ff),
      .bundle (bundle)
   );

   xmt_rsp_queue u_rsp_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (proc),
      .bundle (bundle),
      .status (q_status),
      .rsp    (rsp_ch)
   );

   // The result queue never holds more than its depth.
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_status.count <= xmt_pkg::RSP_Q_CNT_W'(xmt_pkg::RSP_Q_DEPTH))
      else $error("result queue overfilled");

   // A request that produces results makes a result visible next cycle.
   a_result_shows: assert property (@(posedge clock) disable iff (reset)
      (proc && bundle.count != 2'd0) |=> rsp_ch.valid)
      else $error("results of a processed request did not appear");

   // Error results never close a construct.
   a_error_not_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.kind == xmt_pkg::KIND_ERROR) |-> !rsp_ch.construct_end)
      else $error("error result flagged as construct end");

   // A start tag close always leaves at least one open element.
   a_start_depth: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.construct_end &&
       rsp_ch.construct_type == xmt_pkg::CT_START_TAG) |-> (rsp_ch.element_depth != 8'd0))
      else $error("start tag closed with zero depth");

endmodule
